/* rtl/lcp_pkg.sv */
// shared types and constants for the lru id cache policy block
package lcp_pkg;

  localparam int LCP_ENTRIES = 16;
  localparam int LCP_ID_W    = 31;
  localparam int LCP_CAP_W   = 5;
  localparam logic [LCP_CAP_W-1:0] LCP_CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_LOADED   = 2'd1,
    ST_NOTFOUND = 2'd2
  } lcp_status_t;

  // per-entry flags produced by the scan unit
  typedef struct packed {
    logic hit;    // valid and tag matches
    logic older;  // valid and older than the best victim so far
    logic empty;  // entry not valid
    logic age;    // valid and due one step older
  } lcp_probe_t;

endpackage

/* rtl/lru_id_cache_policy_top.sv */
// top level of the fully associative lru id cache policy block
// - request channel: in_valid / in_stall with request_id and backing_present;
//   a beat is taken when in_valid is high and in_stall is low
// - result channel: out_valid / out_stall with status, evict_valid and
//   evicted_id; exactly one result beat per request beat
// - config channel: cfg_valid / cfg_ready with cache_capacity; cfg_ready is
//   always high, write only while no request is in flight
// - each request is handled by a small sequencer that walks the entries one
//   per cycle through a single compare unit: a lookup pass over all entries
//   (tag match, oldest valid entry, first empty slot), a decision step,
//   then, but for a miss without backing, an aging pass rewriting every rank
// - the result is loaded into the output register after the two passes over
//   the tag and rank rams (after the lookup pass alone for a miss without
//   backing); a new request is taken only once the sequencer is back in idle
//   with the previous result loaded into the output register
// - a finished result sits in the output register; the next request may be
//   taken while it waits, and the sequencer holds in its last step when the
//   receiver stalls with a result still pending
// - reset empties the cache (all entries invalid, occupancy zero) and sets
//   the capacity to 16; the tag and rank rams need no clearing
module lru_id_cache_policy_top
  import lcp_pkg::*;
#(
  parameter int ENTRIES = LCP_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [LCP_ID_W-1:0]  request_id,
  input  logic                 backing_present,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic                 evict_valid,
  output logic [LCP_ID_W-1:0]  evicted_id,
  // config channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LCP_CAP_W-1:0] cache_capacity
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > LCP_CAP_W) ? OCC_W : LCP_CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_LTAIL,
    S_DECIDE,
    S_AGE,
    S_ATAIL,
    S_OUT
  } state_t;

  state_t state;

  // request and scan bookkeeping
  logic [LCP_ID_W-1:0]  req_id;
  logic                 req_backing;
  logic [IDX_W-1:0]     idx;
  logic                 rd_live;
  logic [IDX_W-1:0]     rd_idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_slot;
  logic [RANK_W-1:0]    hit_rank;
  logic                 have_best;
  logic [RANK_W-1:0]    best_rank;
  logic [IDX_W-1:0]     vic_slot;
  logic [LCP_ID_W-1:0]  vic_tag;
  logic                 free_found;
  logic [IDX_W-1:0]     free_slot;
  logic                 age_all;
  logic                 tgt_live;
  logic [IDX_W-1:0]     tgt_slot;

  // cache state
  logic [ENTRIES-1:0]   valid_bits;
  logic [OCC_W-1:0]     occupancy;
  logic [LCP_CAP_W-1:0] cap;

  // pending result
  lcp_status_t          res_status;
  logic                 res_evict;
  logic [LCP_ID_W-1:0]  res_evicted;

  // ram ports
  logic [LCP_ID_W-1:0]  tag_rdata;
  logic [RANK_W-1:0]    rank_rdata;
  logic                 tag_we;
  logic [IDX_W-1:0]     tag_waddr;
  logic                 rank_we;
  logic [RANK_W-1:0]    rank_wdata;

  // scan unit
  lcp_probe_t           probe;
  logic [RANK_W-1:0]    rank_inc;

  // decision logic
  logic [CMP_W-1:0]     eff_cap;
  logic                 full;
  logic                 do_evict;
  logic                 do_install;
  logic [IDX_W-1:0]     inst_slot;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  lcp_ram #(
    .WIDTH (LCP_ID_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (req_id),
    .raddr (idx),
    .rdata (tag_rdata)
  );

  lcp_ram #(
    .WIDTH (RANK_W),
    .DEPTH (ENTRIES)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rd_idx),
    .wdata (rank_wdata),
    .raddr (idx),
    .rdata (rank_rdata)
  );

  lcp_scan #(
    .RANK_W (RANK_W)
  ) u_scan (
    .entry_valid (valid_bits[rd_idx]),
    .entry_tag   (tag_rdata),
    .entry_rank  (rank_rdata),
    .req_id      (req_id),
    .have_best   (have_best),
    .best_rank   (best_rank),
    .age_all     (age_all),
    .hit_rank    (hit_rank),
    .probe       (probe),
    .rank_inc    (rank_inc)
  );

  // capacity zero acts as one, above the entry count acts as the entry count
  always_comb begin
    if (cap == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap);
    end
  end

  assign full     = (CMP_W'(occupancy) >= eff_cap) && (occupancy != '0);
  assign do_evict = full && have_best;

  // the freed victim slot competes with the first empty slot seen
  always_comb begin
    if (do_evict) begin
      do_install = 1'b1;
      inst_slot  = (free_found && (free_slot < vic_slot)) ? free_slot : vic_slot;
    end else begin
      do_install = free_found;
      inst_slot  = free_slot;
    end
  end

  assign tag_we    = (state == S_DECIDE) && !hit_found && req_backing && do_install;
  assign tag_waddr = inst_slot;

  // aging pass writes back each rank in the cycle after its read
  assign rank_we = rd_live && ((state == S_AGE) || (state == S_ATAIL));

  always_comb begin
    if (tgt_live && (rd_idx == tgt_slot)) begin
      rank_wdata = '0;
    end else if (probe.age) begin
      rank_wdata = rank_inc;
    end else begin
      rank_wdata = rank_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      rd_live    <= 1'b0;
      valid_bits <= '0;
      occupancy  <= '0;
      cap        <= LCP_CAP_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap <= cache_capacity;
      end

      // the output step reloads out_valid itself
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      rd_live <= (state == S_LOOK) || (state == S_AGE);
      rd_idx  <= idx;

      // lookup pass results
      if (rd_live && ((state == S_LOOK) || (state == S_LTAIL))) begin
        if (probe.hit && !hit_found) begin
          hit_found <= 1'b1;
          hit_slot  <= rd_idx;
          hit_rank  <= rank_rdata;
        end
        if (probe.older) begin
          have_best <= 1'b1;
          best_rank <= rank_rdata;
          vic_slot  <= rd_idx;
          vic_tag   <= tag_rdata;
        end
        if (probe.empty && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= rd_idx;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_id      <= request_id;
            req_backing <= backing_present;
            hit_found   <= 1'b0;
            have_best   <= 1'b0;
            free_found  <= 1'b0;
            idx         <= '0;
            state       <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (idx == LAST_IDX) begin
            state <= S_LTAIL;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_LTAIL: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          idx         <= '0;
          res_evict   <= 1'b0;
          res_evicted <= '0;
          if (hit_found) begin
            res_status <= ST_HIT;
            age_all    <= 1'b0;
            tgt_live   <= 1'b1;
            tgt_slot   <= hit_slot;
            state      <= S_AGE;
          end else if (!req_backing) begin
            res_status <= ST_NOTFOUND;
            state      <= S_OUT;
          end else begin
            res_status <= ST_LOADED;
            age_all    <= 1'b1;
            tgt_live   <= do_install;
            tgt_slot   <= inst_slot;
            if (do_evict) begin
              res_evict   <= 1'b1;
              res_evicted <= vic_tag;
            end
            // evict then install; the installed slot is marked last
            begin
              logic [ENTRIES-1:0] vb;
              vb = valid_bits;
              if (do_evict) begin
                vb[vic_slot] = 1'b0;
              end
              if (do_install) begin
                vb[inst_slot] = 1'b1;
              end
              valid_bits <= vb;
            end
            occupancy <= occupancy - OCC_W'(do_evict) + OCC_W'(do_install);
            state     <= S_AGE;
          end
        end
        S_AGE: begin
          if (idx == LAST_IDX) begin
            state <= S_ATAIL;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_ATAIL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // hold while an older result is still stalled
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            evict_valid <= res_evict;
            evicted_id  <= res_evicted;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/lcp_ram.sv */
// generic single write port ram with registered read
module lcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lcp_scan.sv */
// shared compare unit applied to one cache entry per cycle
module lcp_scan
  import lcp_pkg::*;
#(
  parameter int RANK_W = 4
) (
  input  logic                entry_valid,
  input  logic [LCP_ID_W-1:0] entry_tag,
  input  logic [RANK_W-1:0]   entry_rank,
  input  logic [LCP_ID_W-1:0] req_id,
  input  logic                have_best,
  input  logic [RANK_W-1:0]   best_rank,
  input  logic                age_all,
  input  logic [RANK_W-1:0]   hit_rank,
  output lcp_probe_t          probe,
  output logic [RANK_W-1:0]   rank_inc
);

  always_comb begin
    probe.hit   = entry_valid && (entry_tag == req_id);
    probe.older = entry_valid && (!have_best || (entry_rank > best_rank));
    probe.empty = !entry_valid;
    probe.age   = entry_valid && (age_all || (entry_rank < hit_rank));
  end

  assign rank_inc = entry_rank + RANK_W'(1);

endmodule
